// ----- hw/rtl/cas_pkg.sv -----
package cas_pkg;

    // field widths
    localparam int unsigned MS_W       = 32;
    localparam int unsigned BTN_W      = 3;
    localparam int unsigned HOUR_W     = 5;
    localparam int unsigned MIN_W      = 6;
    localparam int unsigned SEC_W      = 6;
    localparam int unsigned WDAY_W     = 3;
    localparam int unsigned DATE_W     = 5;
    localparam int unsigned MONTH_W    = 4;
    localparam int unsigned YEAR_W     = 7;
    localparam int unsigned MODE_W     = 3;
    localparam int unsigned DEBOUNCE_W = 10;
    localparam int unsigned LEAD_W     = 6;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_FIRST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_YEAR_LAST  = 2'd3;

    // configuration reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = 10'd50;
    localparam logic [LEAD_W-1:0]     LEAD_RST       = 6'd2;
    localparam logic [YEAR_W-1:0]     YEAR_FIRST_RST = 7'd24;
    localparam logic [YEAR_W-1:0]     YEAR_LAST_RST  = 7'd30;

    // button codes
    localparam logic [BTN_W-1:0] BTN_TIME_SET  = 3'd0;
    localparam logic [BTN_W-1:0] BTN_INC       = 3'd1;
    localparam logic [BTN_W-1:0] BTN_DATE_SET  = 3'd2;
    localparam logic [BTN_W-1:0] BTN_ALARM     = 3'd3;
    localparam logic [BTN_W-1:0] BTN_ALARM_INC = 3'd4;

    // setting mode codes, shared by the time/date and alarm modes
    localparam logic [MODE_W-1:0] MODE_SHOW    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HOUR    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MINUTE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SECOND  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WEEKDAY = 3'd4;
    localparam logic [MODE_W-1:0] MODE_YEAR    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_MONTH   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_DATE    = 3'd7;

    // hour step, 23 wraps to 0
    function automatic logic [HOUR_W-1:0] f_next_hour(input logic [HOUR_W-1:0] v);
        logic [HOUR_W:0] n;
        n = {1'b0, v} + 6'd1;
        return (n > 6'd23) ? '0 : n[HOUR_W-1:0];
    endfunction

    // minute or second step, 59 wraps to 0
    function automatic logic [MIN_W-1:0] f_next_sixty(input logic [MIN_W-1:0] v);
        logic [MIN_W:0] n;
        n = {1'b0, v} + 7'd1;
        return (n > 7'd59) ? '0 : n[MIN_W-1:0];
    endfunction

    // weekday step, 7 wraps to 1
    function automatic logic [WDAY_W-1:0] f_next_wday(input logic [WDAY_W-1:0] v);
        logic [WDAY_W:0] n;
        n = {1'b0, v} + 4'd1;
        return (n > 4'd7) ? 3'd1 : n[WDAY_W-1:0];
    endfunction

    // month step, 12 wraps to 1
    function automatic logic [MONTH_W-1:0] f_next_month(input logic [MONTH_W-1:0] v);
        logic [MONTH_W:0] n;
        n = {1'b0, v} + 5'd1;
        return (n > 5'd12) ? 4'd1 : n[MONTH_W-1:0];
    endfunction

    // days in month, leap year when year mod 4 is zero
    function automatic logic [DATE_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                      input logic [YEAR_W-1:0] y);
        logic [DATE_W-1:0] len;
        if (m == 4'd2) begin
            len = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
        end else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
            len = 5'd30;
        end else begin
            len = 5'd31;
        end
        return len;
    endfunction

    // date step, wraps to 1 past the month length
    function automatic logic [DATE_W-1:0] f_next_date(input logic [DATE_W-1:0] d,
                                                      input logic [MONTH_W-1:0] m,
                                                      input logic [YEAR_W-1:0] y);
        logic [DATE_W:0] n;
        n = {1'b0, d} + 6'd1;
        return (n > {1'b0, f_month_len(m, y)}) ? 5'd1 : n[DATE_W-1:0];
    endfunction

    // year step, wraps to the first year past the last year
    function automatic logic [YEAR_W-1:0] f_next_year(input logic [YEAR_W-1:0] y,
                                                      input logic [YEAR_W-1:0] first,
                                                      input logic [YEAR_W-1:0] last);
        logic [YEAR_W:0] n;
        n = {1'b0, y} + 8'd1;
        return (n > {1'b0, last}) ? first : n[YEAR_W-1:0];
    endfunction

    // (minute + lead) mod 60, the sum stays below 180
    function automatic logic [MIN_W-1:0] f_add_lead(input logic [MIN_W-1:0] mi,
                                                     input logic [LEAD_W-1:0] lead);
        logic [MIN_W:0] s;
        s = {1'b0, mi} + {1'b0, lead};
        if (s >= 7'd120) begin
            s = s - 7'd120;
        end else if (s >= 7'd60) begin
            s = s - 7'd60;
        end
        return s[MIN_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/cas_in_if.sv -----
interface cas_in_if;
    import cas_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [BTN_W-1:0]     button;
    logic [MS_W-1:0]      now_ms;
    logic [HOUR_W-1:0]    hour;
    logic [MIN_W-1:0]     minute;
    logic [SEC_W-1:0]     second;
    logic [WDAY_W-1:0]    weekday;
    logic [DATE_W-1:0]    day_of_month;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;

    modport source (
        output valid, func, button, now_ms, hour, minute, second, weekday,
               day_of_month, month, year,
        input  ready
    );

    modport sink (
        input  valid, func, button, now_ms, hour, minute, second, weekday,
               day_of_month, month, year,
        output ready
    );
endinterface

// ----- hw/rtl/cas_out_if.sv -----
interface cas_out_if;
    import cas_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 alarm_on;
    logic [MODE_W-1:0]    time_mode;
    logic [MODE_W-1:0]    alarm_mode;
    logic                 write_time;
    logic                 write_date;
    logic [HOUR_W-1:0]    out_hour;
    logic [MIN_W-1:0]     out_minute;
    logic [SEC_W-1:0]     out_second;
    logic [WDAY_W-1:0]    out_weekday;
    logic [DATE_W-1:0]    out_date;
    logic [MONTH_W-1:0]   out_month;
    logic [YEAR_W-1:0]    out_year;

    modport source (
        output valid, alarm_on, time_mode, alarm_mode, write_time, write_date,
               out_hour, out_minute, out_second, out_weekday, out_date,
               out_month, out_year,
        input  ready
    );

    modport sink (
        input  valid, alarm_on, time_mode, alarm_mode, write_time, write_date,
               out_hour, out_minute, out_second, out_weekday, out_date,
               out_month, out_year,
        output ready
    );
endinterface

// ----- hw/rtl/clock_alarm_set_controller.sv -----
// result: registered, valid in the cycle after its input transaction is accepted
// throughput: one transaction per cycle; state update and result share one
//   register stage, and a held result that is not taken stalls the input
// reset: synchronous active low; modes, edit and alarm fields and the last
//   press time clear to zero, config registers load their default values
module clock_alarm_set_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [cas_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cas_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cas_in_if.sink                        i_in,
    cas_out_if.source                     o_out
);
    import cas_pkg::*;

    // configuration registers
    logic [DEBOUNCE_W-1:0] r_debounce;
    logic [LEAD_W-1:0]     r_lead;
    logic [YEAR_W-1:0]     r_year_first;
    logic [YEAR_W-1:0]     r_year_last;

    // setting state
    logic [MODE_W-1:0]  r_time_mode,  n_time_mode;
    logic [MODE_W-1:0]  r_alarm_mode, n_alarm_mode;
    logic [MS_W-1:0]    r_last_press, n_last_press;
    logic [HOUR_W-1:0]  r_edit_hour,  n_edit_hour;
    logic [MIN_W-1:0]   r_edit_min,   n_edit_min;
    logic [SEC_W-1:0]   r_edit_sec,   n_edit_sec;
    logic [WDAY_W-1:0]  r_edit_wday,  n_edit_wday;
    logic [DATE_W-1:0]  r_edit_date,  n_edit_date;
    logic [MONTH_W-1:0] r_edit_month, n_edit_month;
    logic [YEAR_W-1:0]  r_edit_year,  n_edit_year;
    logic [HOUR_W-1:0]  r_alm_hour,   n_alm_hour;
    logic [MIN_W-1:0]   r_alm_min,    n_alm_min;
    logic [WDAY_W-1:0]  r_alm_wday,   n_alm_wday;
    logic [DATE_W-1:0]  r_alm_date,   n_alm_date;
    logic [MONTH_W-1:0] r_alm_month,  n_alm_month;
    logic [YEAR_W-1:0]  r_alm_year,   n_alm_year;

    logic w_acc;
    logic w_press_ok;
    logic n_wt;
    logic n_wd;
    logic n_alarm_on;
    logic [MS_W-1:0] w_elapsed;
    logic r_out_valid;

    // input handshake, the output register frees when its result is taken
    assign i_in.ready = i_rst_n & (~r_out_valid | o_out.ready);
    assign w_acc      = i_in.valid & i_in.ready;

    // debounce with wrapping subtraction
    assign w_elapsed  = i_in.now_ms - r_last_press;
    assign w_press_ok = ~i_in.func & (w_elapsed >= {{(MS_W-DEBOUNCE_W){1'b0}}, r_debounce});

    // next state for one transaction
    always_comb begin
        n_time_mode  = r_time_mode;
        n_alarm_mode = r_alarm_mode;
        n_last_press = r_last_press;
        n_edit_hour  = r_edit_hour;
        n_edit_min   = r_edit_min;
        n_edit_sec   = r_edit_sec;
        n_edit_wday  = r_edit_wday;
        n_edit_date  = r_edit_date;
        n_edit_month = r_edit_month;
        n_edit_year  = r_edit_year;
        n_alm_hour   = r_alm_hour;
        n_alm_min    = r_alm_min;
        n_alm_wday   = r_alm_wday;
        n_alm_date   = r_alm_date;
        n_alm_month  = r_alm_month;
        n_alm_year   = r_alm_year;
        n_wt         = 1'b0;
        n_wd         = 1'b0;

        if (w_acc && w_press_ok) begin
            n_last_press = i_in.now_ms;
            case (i_in.button)
                BTN_TIME_SET: begin
                    if (r_time_mode == MODE_SHOW) begin
                        n_time_mode = MODE_HOUR;
                        n_edit_hour = i_in.hour;
                        n_edit_min  = i_in.minute;
                        n_edit_sec  = i_in.second;
                    end else if (r_time_mode == MODE_SECOND) begin
                        n_time_mode = MODE_SHOW;
                        n_wt        = 1'b1;
                    end else if (r_time_mode > MODE_SECOND) begin
                        n_time_mode = MODE_SHOW;
                    end else begin
                        n_time_mode = r_time_mode + 3'd1;
                    end
                end
                BTN_DATE_SET: begin
                    if (r_time_mode == MODE_SHOW) begin
                        n_time_mode  = MODE_WEEKDAY;
                        n_edit_wday  = i_in.weekday;
                        n_edit_date  = i_in.day_of_month;
                        n_edit_month = i_in.month;
                        n_edit_year  = i_in.year;
                    end else if (r_time_mode == MODE_DATE) begin
                        n_time_mode = MODE_SHOW;
                        n_wd        = 1'b1;
                    end else begin
                        n_time_mode = r_time_mode + 3'd1;
                    end
                end
                BTN_ALARM: begin
                    if (r_alarm_mode == MODE_SHOW) begin
                        n_alarm_mode = MODE_HOUR;
                        n_alm_hour   = i_in.hour;
                        n_alm_min    = f_add_lead(i_in.minute, r_lead);
                        n_alm_wday   = i_in.weekday;
                        n_alm_date   = i_in.day_of_month;
                        n_alm_month  = i_in.month;
                        n_alm_year   = i_in.year;
                    end else if (r_alarm_mode == MODE_MINUTE) begin
                        n_alarm_mode = MODE_YEAR;
                    end else begin
                        // date mode rolls over to idle
                        n_alarm_mode = r_alarm_mode + 3'd1;
                    end
                end
                BTN_INC: begin
                    case (r_time_mode)
                        MODE_HOUR:    n_edit_hour  = f_next_hour(r_edit_hour);
                        MODE_MINUTE:  n_edit_min   = f_next_sixty(r_edit_min);
                        MODE_SECOND:  n_edit_sec   = f_next_sixty(r_edit_sec);
                        MODE_WEEKDAY: n_edit_wday  = f_next_wday(r_edit_wday);
                        MODE_YEAR:    n_edit_year  = f_next_year(r_edit_year,
                                                                 r_year_first, r_year_last);
                        MODE_MONTH:   n_edit_month = f_next_month(r_edit_month);
                        MODE_DATE:    n_edit_date  = f_next_date(r_edit_date,
                                                                 r_edit_month, r_edit_year);
                        default: ;
                    endcase
                end
                BTN_ALARM_INC: begin
                    case (r_alarm_mode)
                        MODE_HOUR:    n_alm_hour  = f_next_hour(r_alm_hour);
                        MODE_MINUTE:  n_alm_min   = f_next_sixty(r_alm_min);
                        MODE_WEEKDAY: n_alm_wday  = f_next_wday(r_alm_wday);
                        MODE_YEAR:    n_alm_year  = f_next_year(r_alm_year,
                                                                r_year_first, r_year_last);
                        MODE_MONTH:   n_alm_month = f_next_month(r_alm_month);
                        MODE_DATE:    n_alm_date  = f_next_date(r_alm_date,
                                                                r_alm_month, r_alm_year);
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // alarm compare against the updated alarm fields
    assign n_alarm_on = (i_in.hour == n_alm_hour) && (i_in.minute == n_alm_min) &&
                        (i_in.weekday == n_alm_wday) && (i_in.day_of_month == n_alm_date) &&
                        (i_in.month == n_alm_month) && (i_in.year == n_alm_year);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= DEBOUNCE_RST;
            r_lead       <= LEAD_RST;
            r_year_first <= YEAR_FIRST_RST;
            r_year_last  <= YEAR_LAST_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[DEBOUNCE_W-1:0];
                CFG_LEAD:       r_lead       <= i_cfg_data[LEAD_W-1:0];
                CFG_YEAR_FIRST: r_year_first <= i_cfg_data[YEAR_W-1:0];
                CFG_YEAR_LAST:  r_year_last  <= i_cfg_data[YEAR_W-1:0];
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_mode  <= MODE_SHOW;
            r_alarm_mode <= MODE_SHOW;
            r_last_press <= '0;
            r_edit_hour  <= '0;
            r_edit_min   <= '0;
            r_edit_sec   <= '0;
            r_edit_wday  <= '0;
            r_edit_date  <= '0;
            r_edit_month <= '0;
            r_edit_year  <= '0;
            r_alm_hour   <= '0;
            r_alm_min    <= '0;
            r_alm_wday   <= '0;
            r_alm_date   <= '0;
            r_alm_month  <= '0;
            r_alm_year   <= '0;
        end else begin
            r_time_mode  <= n_time_mode;
            r_alarm_mode <= n_alarm_mode;
            r_last_press <= n_last_press;
            r_edit_hour  <= n_edit_hour;
            r_edit_min   <= n_edit_min;
            r_edit_sec   <= n_edit_sec;
            r_edit_wday  <= n_edit_wday;
            r_edit_date  <= n_edit_date;
            r_edit_month <= n_edit_month;
            r_edit_year  <= n_edit_year;
            r_alm_hour   <= n_alm_hour;
            r_alm_min    <= n_alm_min;
            r_alm_wday   <= n_alm_wday;
            r_alm_date   <= n_alm_date;
            r_alm_month  <= n_alm_month;
            r_alm_year   <= n_alm_year;
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, write fields read zero without their strobe
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            o_out.alarm_on    <= n_alarm_on;
            o_out.time_mode   <= n_time_mode;
            o_out.alarm_mode  <= n_alarm_mode;
            o_out.write_time  <= n_wt;
            o_out.write_date  <= n_wd;
            o_out.out_hour    <= n_wt ? n_edit_hour  : '0;
            o_out.out_minute  <= n_wt ? n_edit_min   : '0;
            o_out.out_second  <= n_wt ? n_edit_sec   : '0;
            o_out.out_weekday <= n_wd ? n_edit_wday  : '0;
            o_out.out_date    <= n_wd ? n_edit_date  : '0;
            o_out.out_month   <= n_wd ? n_edit_month : '0;
            o_out.out_year    <= n_wd ? n_edit_year  : '0;
        end
    end

    assign o_out.valid = r_out_valid;

endmodule

// ----- tb/testbench.sv -----
module testbench;
    import cas_pkg::*;

    localparam int PHASES      = 5;
    localparam int PHASE_LEN   = 385;
    localparam int STALL_LIMIT = 2000;
    localparam int ERR_SHOWN   = 10;

    // button codes the block accepts and ignores
    localparam logic [BTN_W-1:0] BTN_UNUSED_LO = 3'd5;
    localparam logic [BTN_W-1:0] BTN_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic               func;
        logic [BTN_W-1:0]   button;
        logic [MS_W-1:0]    now_ms;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [WDAY_W-1:0]  weekday;
        logic [DATE_W-1:0]  day_of_month;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } event_t;

    typedef struct packed {
        logic               alarm_on;
        logic [MODE_W-1:0]  time_mode;
        logic [MODE_W-1:0]  alarm_mode;
        logic               write_time;
        logic               write_date;
        logic [HOUR_W-1:0]  out_hour;
        logic [MIN_W-1:0]   out_minute;
        logic [SEC_W-1:0]   out_second;
        logic [WDAY_W-1:0]  out_weekday;
        logic [DATE_W-1:0]  out_date;
        logic [MONTH_W-1:0] out_month;
        logic [YEAR_W-1:0]  out_year;
    } status_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    cas_in_if  evt_if ();
    cas_out_if sts_if ();

    clock_alarm_set_controller DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (evt_if.sink),
        .o_out      (sts_if.source)
    );

    // shadow of the configuration registers
    int unsigned cfg_debounce   = DEBOUNCE_RST;
    int          cfg_lead       = LEAD_RST;
    int          cfg_year_first = YEAR_FIRST_RST;
    int          cfg_year_last  = YEAR_LAST_RST;

    // shadow of the setter state
    int              mode_time, mode_alarm;
    logic [MS_W-1:0] last_press = '0;
    int              edit_hour, edit_minute, edit_second, edit_weekday;
    int              edit_date, edit_month, edit_year;
    int              alm_hour, alm_minute, alm_weekday, alm_date, alm_month, alm_year;

    event_t          events_to_send[$];
    status_t         statuses_due[$];
    event_t          held_ev;
    status_t         got_sts, want_sts;
    logic [MS_W-1:0] tick_ms = '0;
    int              batch_len;
    int              err_count;
    int              quiet_cycles;
    int              tx_gap, tx_calm, rx_gap, rx_calm;

    // counter step with wrap to a low value past the top
    function automatic int step_up(input int v, input int top, input int low);
        return (v + 1 > top) ? low : v + 1;
    endfunction

    function automatic int days_in_month(input int m, input int y);
        if (m == 2) return (y % 4 == 0) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    // apply one transaction to the shadow state and build the status it yields
    function automatic status_t predict_status(input event_t ev);
        status_t         st;
        logic [MS_W-1:0] elapsed;
        logic            write_t;
        logic            write_d;
        st      = '0;
        write_t = 1'b0;
        write_d = 1'b0;
        elapsed = ev.now_ms - last_press;
        if (!ev.func && elapsed >= MS_W'(cfg_debounce)) begin
            last_press = ev.now_ms;
            case (ev.button)
                BTN_TIME_SET: begin
                    if (mode_time == MODE_SHOW) begin
                        mode_time   = MODE_HOUR;
                        edit_hour   = ev.hour;
                        edit_minute = ev.minute;
                        edit_second = ev.second;
                    end else if (mode_time == MODE_SECOND) begin
                        mode_time = MODE_SHOW;
                        write_t   = 1'b1;
                    end else if (mode_time > MODE_SECOND) begin
                        mode_time = MODE_SHOW;
                    end else begin
                        mode_time = mode_time + 1;
                    end
                end
                BTN_DATE_SET: begin
                    if (mode_time == MODE_SHOW) begin
                        mode_time    = MODE_WEEKDAY;
                        edit_weekday = ev.weekday;
                        edit_date    = ev.day_of_month;
                        edit_month   = ev.month;
                        edit_year    = ev.year;
                    end else if (mode_time == MODE_DATE) begin
                        mode_time = MODE_SHOW;
                        write_d   = 1'b1;
                    end else begin
                        mode_time = mode_time + 1;
                    end
                end
                BTN_ALARM: begin
                    if (mode_alarm == MODE_SHOW) begin
                        mode_alarm  = MODE_HOUR;
                        alm_hour    = ev.hour;
                        alm_minute  = (int'(ev.minute) + cfg_lead) % 60;
                        alm_weekday = ev.weekday;
                        alm_date    = ev.day_of_month;
                        alm_month   = ev.month;
                        alm_year    = ev.year;
                    end else if (mode_alarm == MODE_MINUTE) begin
                        mode_alarm = MODE_YEAR;
                    end else if (mode_alarm == MODE_DATE) begin
                        mode_alarm = MODE_SHOW;
                    end else begin
                        mode_alarm = mode_alarm + 1;
                    end
                end
                BTN_INC: begin
                    case (mode_time)
                        MODE_HOUR:    edit_hour    = step_up(edit_hour, 23, 0);
                        MODE_MINUTE:  edit_minute  = step_up(edit_minute, 59, 0);
                        MODE_SECOND:  edit_second  = step_up(edit_second, 59, 0);
                        MODE_WEEKDAY: edit_weekday = step_up(edit_weekday, 7, 1) % 8;
                        MODE_YEAR:
                            edit_year = step_up(edit_year, cfg_year_last, cfg_year_first);
                        MODE_MONTH:   edit_month   = step_up(edit_month, 12, 1);
                        MODE_DATE:    edit_date    = step_up(edit_date,
                                          days_in_month(edit_month, edit_year), 1);
                        default: ;
                    endcase
                end
                BTN_ALARM_INC: begin
                    case (mode_alarm)
                        MODE_HOUR:    alm_hour    = step_up(alm_hour, 23, 0);
                        MODE_MINUTE:  alm_minute  = step_up(alm_minute, 59, 0);
                        MODE_WEEKDAY: alm_weekday = step_up(alm_weekday, 7, 1) % 8;
                        MODE_YEAR:
                            alm_year = step_up(alm_year, cfg_year_last, cfg_year_first);
                        MODE_MONTH:   alm_month   = step_up(alm_month, 12, 1);
                        MODE_DATE:    alm_date    = step_up(alm_date,
                                          days_in_month(alm_month, alm_year), 1);
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
        st.alarm_on   = (int'(ev.hour) == alm_hour && int'(ev.minute) == alm_minute &&
                         int'(ev.weekday) == alm_weekday &&
                         int'(ev.day_of_month) == alm_date &&
                         int'(ev.month) == alm_month && int'(ev.year) == alm_year);
        st.time_mode  = MODE_W'(mode_time);
        st.alarm_mode = MODE_W'(mode_alarm);
        if (write_t) begin
            st.write_time = 1'b1;
            st.out_hour   = HOUR_W'(edit_hour);
            st.out_minute = MIN_W'(edit_minute);
            st.out_second = SEC_W'(edit_second);
        end
        if (write_d) begin
            st.write_date  = 1'b1;
            st.out_weekday = WDAY_W'(edit_weekday);
            st.out_date    = DATE_W'(edit_date);
            st.out_month   = MONTH_W'(edit_month);
            st.out_year    = YEAR_W'(edit_year);
        end
        return st;
    endfunction

    function automatic string show_status(input status_t s);
        return $sformatf({"alarm=%0d tmode=%0d amode=%0d wt=%0d wd=%0d ",
                          "time=%0d:%0d:%0d wday=%0d date=%0d-%0d-%0d"},
                         s.alarm_on, s.time_mode, s.alarm_mode, s.write_time,
                         s.write_date, s.out_hour, s.out_minute, s.out_second,
                         s.out_weekday, s.out_year, s.out_month, s.out_date);
    endfunction

    // idle length: mostly none or short, a few long, with calm stretches
    function automatic int draw_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // field value biased toward its limits
    function automatic int pick(input int lo, input int hi);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 2) return hi;
        if (roll < 3) return lo;
        return $urandom_range(lo, hi);
    endfunction

    function automatic event_t rand_clock();
        event_t ev;
        ev         = '0;
        ev.hour    = HOUR_W'(pick(0, 23));
        ev.minute  = MIN_W'(pick(0, 59));
        ev.second  = SEC_W'(pick(0, 59));
        ev.weekday = WDAY_W'(pick(0, 7));
        ev.day_of_month = ($urandom_range(0, 3) == 0) ? DATE_W'($urandom_range(28, 31))
                                                      : DATE_W'(pick(1, 31));
        ev.month   = MONTH_W'(pick(1, 12));
        ev.year    = YEAR_W'(pick(0, 99));
        return ev;
    endfunction

    // millisecond tick for the next press, mostly past the debounce window
    function automatic logic [MS_W-1:0] next_tick();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            tick_ms = tick_ms + MS_W'(cfg_debounce) + MS_W'($urandom_range(0, 300));
        end else if (roll < 92) begin
            tick_ms = tick_ms + MS_W'($urandom_range(0, cfg_debounce));
        end else begin
            tick_ms = tick_ms + MS_W'($urandom);
        end
        return tick_ms;
    endfunction

    function automatic void enqueue(input event_t ev);
        events_to_send.push_back(ev);
        batch_len++;
    endfunction

    function automatic event_t press(input logic [BTN_W-1:0] btn);
        event_t ev;
        ev        = rand_clock();
        ev.button = btn;
        ev.now_ms = next_tick();
        enqueue(ev);
        return ev;
    endfunction

    function automatic void clock_sample(input event_t ev);
        ev.func   = 1'b1;
        ev.button = BTN_W'($urandom_range(0, 7));
        ev.now_ms = $urandom;
        enqueue(ev);
    endfunction

    function automatic void push_item(input logic func, input logic [BTN_W-1:0] btn,
                                      input logic [MS_W-1:0] now, input int hr,
                                      input int mi, input int se, input int wd,
                                      input int dt, input int mo, input int yr);
        event_t ev;
        ev.func         = func;
        ev.button       = btn;
        ev.now_ms       = now;
        ev.hour         = HOUR_W'(hr);
        ev.minute       = MIN_W'(mi);
        ev.second       = SEC_W'(se);
        ev.weekday      = WDAY_W'(wd);
        ev.day_of_month = DATE_W'(dt);
        ev.month        = MONTH_W'(mo);
        ev.year         = YEAR_W'(yr);
        enqueue(ev);
    endfunction

    // register writes, only while nothing is in flight
    task automatic set_config(input int deb, input int lead, input int yf, input int yl);
        cfg_debounce   = deb;
        cfg_lead       = lead;
        cfg_year_first = yf;
        cfg_year_last  = yl;
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_DEBOUNCE;
        cfg_data <= CFG_DATA_W'(deb);
        @(posedge clk);
        cfg_idx  <= CFG_LEAD;
        cfg_data <= CFG_DATA_W'(lead);
        @(posedge clk);
        cfg_idx  <= CFG_YEAR_FIRST;
        cfg_data <= CFG_DATA_W'(yf);
        @(posedge clk);
        cfg_idx  <= CFG_YEAR_LAST;
        cfg_data <= CFG_DATA_W'(yl);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // known values on every channel signal from time zero
    initial begin
        evt_if.valid        = 1'b0;
        evt_if.func         = 1'b0;
        evt_if.button       = '0;
        evt_if.now_ms       = '0;
        evt_if.hour         = '0;
        evt_if.minute       = '0;
        evt_if.second       = '0;
        evt_if.weekday      = '0;
        evt_if.day_of_month = '0;
        evt_if.month        = '0;
        evt_if.year         = '0;
        sts_if.ready        = 1'b0;
    end

    // input driver: predicts on each accepted transaction, then loads the next
    always @(posedge clk) begin
        if (!rst_n) begin
            evt_if.valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (evt_if.valid && evt_if.ready) begin
                statuses_due.push_back(predict_status(held_ev));
            end
            if (!evt_if.valid || evt_if.ready) begin
                if (tx_gap > 0 || events_to_send.size() == 0) begin
                    evt_if.valid <= 1'b0;
                    if (tx_gap > 0) tx_gap--;
                end else begin
                    held_ev = events_to_send.pop_front();
                    evt_if.valid        <= 1'b1;
                    evt_if.func         <= held_ev.func;
                    evt_if.button       <= held_ev.button;
                    evt_if.now_ms       <= held_ev.now_ms;
                    evt_if.hour         <= held_ev.hour;
                    evt_if.minute       <= held_ev.minute;
                    evt_if.second       <= held_ev.second;
                    evt_if.weekday      <= held_ev.weekday;
                    evt_if.day_of_month <= held_ev.day_of_month;
                    evt_if.month        <= held_ev.month;
                    evt_if.year         <= held_ev.year;
                    tx_gap = draw_gap(tx_calm);
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk) begin
        if (!rst_n) begin
            sts_if.ready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (sts_if.valid && sts_if.ready) begin
                got_sts.alarm_on    = sts_if.alarm_on;
                got_sts.time_mode   = sts_if.time_mode;
                got_sts.alarm_mode  = sts_if.alarm_mode;
                got_sts.write_time  = sts_if.write_time;
                got_sts.write_date  = sts_if.write_date;
                got_sts.out_hour    = sts_if.out_hour;
                got_sts.out_minute  = sts_if.out_minute;
                got_sts.out_second  = sts_if.out_second;
                got_sts.out_weekday = sts_if.out_weekday;
                got_sts.out_date    = sts_if.out_date;
                got_sts.out_month   = sts_if.out_month;
                got_sts.out_year    = sts_if.out_year;
                if (statuses_due.size() == 0) begin
                    if (err_count < ERR_SHOWN)
                        $display("unexpected result: %s", show_status(got_sts));
                    err_count++;
                end else begin
                    want_sts = statuses_due.pop_front();
                    if (got_sts !== want_sts) begin
                        if (err_count < ERR_SHOWN)
                            $display("mismatch at %0t\n  expected %s\n  actual   %s",
                                     $realtime, show_status(want_sts), show_status(got_sts));
                        err_count++;
                    end
                end
            end
            if (rx_gap > 0) begin
                sts_if.ready <= 1'b0;
                rx_gap--;
            end else begin
                sts_if.ready <= 1'b1;
                rx_gap = draw_gap(rx_calm);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (!rst_n || (evt_if.valid && evt_if.ready) || (sts_if.valid && sts_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // reset, then phases of register settings, each with its own stimulus
    initial begin
        int     phase;
        int     kind;
        int     stages;
        bit     no_edits;
        event_t start_ev;
        event_t match_ev;
        event_t noise_ev;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < PHASES; phase++) begin
            batch_len = 0;
            case (phase)
                1: set_config(0, 59, 0, 99);
                2: set_config(1000, 0, 99, 0);
                3: set_config($urandom_range(0, 200), $urandom_range(0, 59),
                              $urandom_range(0, 99), $urandom_range(0, 99));
                4: begin
                    set_config(1, 58, 50, 60);
                    // tick runs across the 32-bit wrap
                    tick_ms = 32'hFFFF_FE00;
                end
                default: begin
                    // press inside the debounce window after reset
                    push_item(0, BTN_TIME_SET, 10, 12, 30, 30, 3, 15, 6, 50);
                    // clock sample at field maxima, button and tick ignored
                    push_item(1, BTN_UNUSED_HI, 32'hFFFF_FFFF, 23, 59, 59, 7, 31, 12, 99);
                    // time walk with hour wrap, ends in a time write
                    push_item(0, BTN_TIME_SET, 100, 23, 59, 59, 1, 1, 1, 0);
                    push_item(0, BTN_INC, 200, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_TIME_SET, 300, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_TIME_SET, 500, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_TIME_SET, 700, 0, 0, 0, 1, 1, 1, 0);
                    // date walk: weekday, year, month and day all wrap
                    push_item(0, BTN_DATE_SET, 800, 0, 0, 0, 7, 31, 12, 30);
                    push_item(0, BTN_INC, 900, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_DATE_SET, 1000, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_INC, 1100, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_DATE_SET, 1200, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_INC, 1300, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_DATE_SET, 1400, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_INC, 1500, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_DATE_SET, 1600, 0, 0, 0, 1, 1, 1, 0);
                    // unused code still restarts the debounce window
                    push_item(0, BTN_UNUSED_LO, 1700, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_TIME_SET, 1720, 0, 0, 0, 1, 1, 1, 0);
                    // time key leaves date setting without a write
                    push_item(0, BTN_DATE_SET, 1800, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_TIME_SET, 1900, 0, 0, 0, 1, 1, 1, 0);
                    // alarm start with minute wrap from the lead, then a hit
                    push_item(0, BTN_ALARM, 2000, 23, 59, 0, 7, 31, 2, 0);
                    push_item(1, BTN_TIME_SET, 0, 23, 1, 0, 7, 31, 2, 0);
                    // alarm walk, leap february day wrap
                    push_item(0, BTN_ALARM, 2100, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_ALARM, 2200, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_ALARM, 2300, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_ALARM, 2400, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_ALARM_INC, 2500, 0, 0, 0, 1, 1, 1, 0);
                    push_item(0, BTN_ALARM, 2600, 0, 0, 0, 1, 1, 1, 0);
                    tick_ms = 2600;
                end
            endcase

            while (batch_len < PHASE_LEN) begin
                kind = $urandom_range(0, 99);
                if (kind < 22) begin
                    // time setting walk, sometimes cut short
                    void'(press(BTN_TIME_SET));
                    stages = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : 3;
                    repeat (stages) begin
                        repeat ($urandom_range(0, 3)) void'(press(BTN_INC));
                        void'(press(BTN_TIME_SET));
                    end
                end else if (kind < 44) begin
                    // date setting walk
                    void'(press(BTN_DATE_SET));
                    stages = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : 4;
                    repeat (stages) begin
                        repeat ($urandom_range(0, 3)) void'(press(BTN_INC));
                        void'(press(BTN_DATE_SET));
                    end
                end else if (kind < 66) begin
                    // alarm walk; without edits a matching sample fires the alarm
                    no_edits = ($urandom_range(0, 2) == 0);
                    start_ev = press(BTN_ALARM);
                    match_ev = start_ev;
                    match_ev.minute = MIN_W'((int'(start_ev.minute) + cfg_lead) % 60);
                    match_ev.second = SEC_W'($urandom_range(0, 59));
                    if ($urandom_range(0, 1) == 1) clock_sample(match_ev);
                    stages = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4) : 5;
                    repeat (stages) begin
                        if (!no_edits)
                            repeat ($urandom_range(0, 2)) void'(press(BTN_ALARM_INC));
                        void'(press(BTN_ALARM));
                    end
                    if (no_edits) clock_sample(match_ev);
                end else if (kind < 80) begin
                    clock_sample(rand_clock());
                end else begin
                    // stray press, any code, often inside the debounce window
                    noise_ev        = rand_clock();
                    noise_ev.button = BTN_W'($urandom_range(0, 7));
                    if ($urandom_range(0, 1) == 1)
                        noise_ev.now_ms = tick_ms + MS_W'($urandom_range(0, cfg_debounce));
                    else
                        noise_ev.now_ms = next_tick();
                    enqueue(noise_ev);
                end
            end

            // drain before touching the registers again
            while (events_to_send.size() != 0 || evt_if.valid || statuses_due.size() != 0)
                @(negedge clk);
        end

        repeat (4) @(posedge clk);
        if (err_count == 0 && statuses_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
